### src/urf_pkg.sv
// Shared types and constants for the ultrasonic range filter.
// No dependencies; every other file imports this package.
`default_nettype none

package urf_pkg;

   // Window and fixed-point geometry (unsigned Q10.8 cm)
   localparam int WINDOW_SIZE = 5;
   localparam int AGE_W       = $clog2(WINDOW_SIZE);
   localparam int Q_FRAC      = 8;
   localparam int CM_W        = 10;
   localparam int Q_W         = CM_W + Q_FRAC;
   localparam int PW_W        = 16;

   // Pulse width to Q8 cm: (pw * 4457) >> 10
   localparam int             CONV_COEF_W = 13;
   localparam int             CONV_SHIFT  = 10;
   localparam int             CONV_W      = PW_W + CONV_COEF_W;
   localparam int             RAW_W       = CONV_W - CONV_SHIFT;
   localparam logic [CONV_COEF_W-1:0] CM_PER_US_Q = 13'd4457;

   // Blend, Q16: new = prev + ((0.2 * (filt - prev)) >>> 16)
   localparam int             ALPHA_W       = 15;
   localparam int             BLEND_SHIFT   = 16;
   localparam int             BLEND_PROD_W  = (Q_W + 1) + (ALPHA_W + 1);
   localparam logic [ALPHA_W-1:0] ALPHA_NEW_Q16 = 15'd13107;

   localparam logic [Q_W-1:0]   Q_MAX      = '1;
   localparam logic [AGE_W-1:0] OLDEST_AGE = AGE_W'(WINDOW_SIZE - 1);

   // CSR reset values
   localparam logic [CM_W-1:0] MIN_RANGE_RST  = 10'd2;
   localparam logic [CM_W-1:0] MAX_RANGE_RST  = 10'd400;
   localparam logic [CM_W-1:0] JUMP_LIMIT_RST = 10'd50;
   localparam logic [CM_W-1:0] STEP_RST       = 10'd15;

   typedef enum logic [1:0] {
      CSR_MIN_RANGE  = 2'd0,
      CSR_MAX_RANGE  = 2'd1,
      CSR_JUMP_LIMIT = 2'd2,
      CSR_STEP       = 2'd3
   } csr_index_type;

   typedef logic [Q_W-1:0] q_type;

   // What a sorter cell shows its neighbors
   typedef struct packed {
      q_type            value;
      logic [AGE_W-1:0] age;
      logic             le;    // value <= incoming word
   } cell_link_type;

endpackage

`default_nettype wire

### src/urf_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on urf_pkg for field widths.
`default_nettype none

interface urf_req_if import urf_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [PW_W-1:0] pulse_width_us;

   modport source (output valid, output pulse_width_us, input ready);
   modport sink   (input valid, input pulse_width_us, output ready);
endinterface

interface urf_rsp_if import urf_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CM_W-1:0] distance_cm;
   logic            rejected;

   modport source (output valid, output distance_cm, output rejected, input ready);
   modport sink   (input valid, input distance_cm, input rejected, output ready);
endinterface

`default_nettype wire

### src/urf_cell.sv
// One cell of the sorted sliding window: holds a sample and its age.
// Depends on urf_pkg. Neighbors are linked through cell_link_type.
`default_nettype none

module urf_cell import urf_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [AGE_W-1:0] reset_age,
   input  wire logic             load,
   input  wire q_type            new_val,
   input  wire cell_link_type    left_link,
   input  wire logic             left_prefix,
   input  wire cell_link_type    right_link,
   output cell_link_type         self_link,
   output logic                  self_prefix,
   output q_type                 next_val
);

   q_type            val_ff, val_in;
   logic [AGE_W-1:0] age_ff, age_in;
   cell_link_type    keep_link;
   cell_link_type    shift_link;
   logic             is_oldest;

   // Oldest entry drops out; survivors compact, new word slots in by rank.
   always_comb begin
      is_oldest   = (age_ff == OLDEST_AGE);
      self_link   = '{value: val_ff, age: age_ff, le: (val_ff <= new_val)};
      self_prefix = left_prefix | is_oldest;
      keep_link   = self_prefix ? right_link : self_link;
      shift_link  = left_prefix ? self_link : left_link;
      if (keep_link.le) begin
         val_in = keep_link.value;
         age_in = keep_link.age + AGE_W'(1);
      end else if (shift_link.le) begin
         val_in = new_val;
         age_in = '0;
      end else begin
         val_in = shift_link.value;
         age_in = shift_link.age + AGE_W'(1);
      end
      next_val = val_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
         age_ff <= reset_age;
      end else if (load) begin
         val_ff <= val_in;
         age_ff <= age_in;
      end
   end

endmodule

`default_nettype wire

### src/urf_chain.sv
// Row of sorter cells kept in ascending order, plus the 1/4-1/2-1/4 weighting
// of the three middle entries. Depends on urf_pkg and urf_cell.
`default_nettype none

module urf_chain import urf_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  load,
   input  wire q_type new_val,
   output q_type      filt
);

   localparam cell_link_type LOW_EDGE  = '{value: '0, age: '0, le: 1'b1};
   localparam cell_link_type HIGH_EDGE = '{value: '0, age: '0, le: 1'b0};

   cell_link_type links    [WINDOW_SIZE];
   logic          prefixes [WINDOW_SIZE];
   q_type         nexts    [WINDOW_SIZE];
   logic [Q_W+1:0] wsum;

   for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
      cell_link_type left_l, right_l;
      logic          left_p;

      if (i == 0) begin : g_lo
         assign left_l = LOW_EDGE;
         assign left_p = 1'b0;
      end else begin : g_mid_l
         assign left_l = links[i-1];
         assign left_p = prefixes[i-1];
      end

      if (i == WINDOW_SIZE - 1) begin : g_hi
         assign right_l = HIGH_EDGE;
      end else begin : g_mid_r
         assign right_l = links[i+1];
      end

      urf_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .reset_age   (AGE_W'(i)),
         .load        (load),
         .new_val     (new_val),
         .left_link   (left_l),
         .left_prefix (left_p),
         .right_link  (right_l),
         .self_link   (links[i]),
         .self_prefix (prefixes[i]),
         .next_val    (nexts[i])
      );
   end

   // Weighted median of the updated window
   always_comb begin
      wsum = (Q_W+2)'(nexts[1]) + {1'b0, nexts[2], 1'b0} + (Q_W+2)'(nexts[3]);
      filt = wsum[Q_W+1:2];
   end

endmodule

`default_nettype wire

### src/ultrasonic_range_filter_core.sv
// Top level of the ultrasonic range filter: conversion, range gate, jump
// limiter, sorted window and low-pass blend. Depends on urf_pkg, urf_if, urf_chain.
//
// Usage
//   req_bus : one word per echo, pulse_width_us in microseconds.
//   rsp_bus : one word per request: distance_cm (filtered, whole cm) and
//             rejected (reading at or outside min/max, last distance repeated).
//   csr_*   : write-only registers, index 0 min range, 1 max range,
//             2 jump limit, 3 step, all whole cm. Write only while no word
//             is in flight.
// Timing
//   Three register stages: input capture, pulse-width multiply, then the
//   filter update (range check, step limit, window insert, sort, blend)
//   into the response register. A request passes the capture, multiply
//   and response registers in that order before its response is valid.
//   Throughput is one word per cycle while rsp_bus is ready; the filter
//   update closes its feedback on the previous output combinationally.
// Reset
//   Synchronous, active high. Window entries and previous output clear to
//   zero, registers return to 2/400/50/15 cm, all stages go empty.
// Back-pressure
//   Each stage advances independently; with rsp_bus stalled the pipe keeps
//   taking words until all three stages hold one, then drops req_bus.ready.
`default_nettype none

module ultrasonic_range_filter_core import urf_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   urf_req_if.sink              req_bus,
   urf_rsp_if.source            rsp_bus,
   input  wire logic            csr_we,
   input  wire logic [1:0]      csr_index,
   input  wire logic [CM_W-1:0] csr_wdata
);

   // ---------------- configuration registers ----------------
   logic [CM_W-1:0] min_range_ff, max_range_ff, jump_limit_ff, step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff  <= MIN_RANGE_RST;
         max_range_ff  <= MAX_RANGE_RST;
         jump_limit_ff <= JUMP_LIMIT_RST;
         step_ff       <= STEP_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_RANGE:  min_range_ff  <= csr_wdata;
            CSR_MAX_RANGE:  max_range_ff  <= csr_wdata;
            CSR_JUMP_LIMIT: jump_limit_ff <= csr_wdata;
            CSR_STEP:       step_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free, s2_fire, s2_free, s1_fire, s1_free, req_fire;

   always_comb begin
      out_free = !out_valid_ff || rsp_bus.ready;
      s2_fire  = s2_valid_ff && out_free;
      s2_free  = !s2_valid_ff || out_free;
      s1_fire  = s1_valid_ff && s2_free;
      s1_free  = !s1_valid_ff || s2_free;
      req_fire = req_bus.valid && s1_free;

      s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_fire ? 1'b1 : (s2_fire ? 1'b0 : s2_valid_ff);
      out_valid_in = s2_fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
   end

   assign req_bus.ready = s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ---------------- stage 1: capture, stage 2: convert ----------------
   logic [PW_W-1:0]   s1_pw_ff;
   logic [CONV_W-1:0] conv_prod;
   logic [RAW_W-1:0]  s2_raw_ff, s2_raw_in;

   always_comb begin
      conv_prod = CONV_W'(s1_pw_ff) * CONV_W'(CM_PER_US_Q);
      s2_raw_in = conv_prod[CONV_W-1:CONV_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (req_fire) s1_pw_ff  <= req_bus.pulse_width_us;
      if (s1_fire)  s2_raw_ff <= s2_raw_in;
   end

   // ---------------- stage 3: filter update ----------------
   q_type                     prev_ff, prev_in;
   logic [RAW_W-1:0]          min_q, max_q;
   logic                      reject;
   q_type                     raw_q, diff, st, up_val, down_val, write_val;
   logic [Q_W:0]              up_sum;
   logic                      rising, jump;
   logic                      load;
   q_type                     filt;
   logic signed [Q_W:0]       delta;
   logic signed [BLEND_PROD_W-1:0] blend_prod;
   logic signed [Q_W:0]       blend_sum;

   always_comb begin
      min_q  = RAW_W'({min_range_ff, {Q_FRAC{1'b0}}});
      max_q  = RAW_W'({max_range_ff, {Q_FRAC{1'b0}}});
      reject = (s2_raw_ff <= min_q) || (s2_raw_ff >= max_q);

      // accepted readings are below max << 8, so they fit Q_W bits
      raw_q    = s2_raw_ff[Q_W-1:0];
      rising   = raw_q > prev_ff;
      diff     = rising ? (raw_q - prev_ff) : (prev_ff - raw_q);
      jump     = (prev_ff != '0) && (diff > {jump_limit_ff, {Q_FRAC{1'b0}}});
      st       = {step_ff, {Q_FRAC{1'b0}}};
      up_sum   = {1'b0, prev_ff} + {1'b0, st};
      up_val   = up_sum[Q_W] ? Q_MAX : up_sum[Q_W-1:0];
      down_val = (prev_ff > st) ? (prev_ff - st) : '0;
      write_val = jump ? (rising ? up_val : down_val) : raw_q;

      load = s2_fire && !reject;
   end

   urf_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .new_val (write_val),
      .filt    (filt)
   );

   // 0.8*prev + 0.2*filt == prev + 0.2*(filt - prev), floor on the shift
   always_comb begin
      delta      = $signed({1'b0, filt}) - $signed({1'b0, prev_ff});
      blend_prod = delta * $signed({1'b0, ALPHA_NEW_Q16});
      blend_sum  = $signed({1'b0, prev_ff}) + blend_prod[BLEND_PROD_W-1:BLEND_SHIFT];
      prev_in    = blend_sum[Q_W-1:0];
   end

   logic [CM_W-1:0] dist_ff;
   logic            rej_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (load) begin
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         dist_ff <= reject ? prev_ff[Q_W-1:Q_FRAC] : prev_in[Q_W-1:Q_FRAC];
         rej_ff  <= reject;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.distance_cm = dist_ff;
   assign rsp_bus.rejected    = rej_ff;

endmodule

`default_nettype wire

### tb/ultrasonic_range_filter_core_tb.sv
// Self-checking testbench for ultrasonic_range_filter_core: directed table, then random phases.
// Depends on urf_pkg, urf_if and the core; predicts each response word in-house.
`default_nettype none

module ultrasonic_range_filter_core_tb import urf_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no handshake at all
   localparam int DRAIN_CYCLES   = 10;     // idle wait after the last response is checked
   localparam int LONG_HOLD      = 60;     // receiver hold-off, fills all three stages
   localparam int HOLD_AT_WORD   = 300;
   localparam int PHASES         = 7;
   localparam int DIR_ROWS       = 31;
   localparam logic [31:0] ALPHA_OLD_Q16 = 32'd52429;

   // One response word as the core reports it
   typedef struct packed {
      logic [CM_W-1:0] distance_cm;
      logic            rejected;
   } range_word_t;

   // What the sender attaches to an offered word: a typed-in answer or none
   typedef struct packed {
      logic        typed;
      range_word_t word;
   } offer_note_t;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_t;

   typedef struct packed {
      row_kind_t       kind;
      csr_index_type   idx;
      logic [PW_W-1:0] value;
      logic            typed;
      range_word_t     word;
   } row_t;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [1:0] csr_index;
   logic [CM_W-1:0] csr_wdata;

   urf_req_if req_bus ();
   urf_rsp_if rsp_bus ();

   ultrasonic_range_filter_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Filter state kept by the testbench, mirrors the core after reset
   // ------------------------------------------------------------------
   logic [CM_W-1:0] min_cm   = MIN_RANGE_RST;
   logic [CM_W-1:0] max_cm   = MAX_RANGE_RST;
   logic [CM_W-1:0] jump_cm  = JUMP_LIMIT_RST;
   logic [CM_W-1:0] step_cm  = STEP_RST;
   q_type           ring_q [WINDOW_SIZE];
   int              slot_q   = 0;
   q_type           prev_out = '0;

   range_word_t distance_q [$];   // expected response words, oldest first
   offer_note_t offered_q  [$];   // notes for words offered but not yet taken

   int  fail_count = 0;
   int  word_count = 0;           // response words checked
   int  gap_pct    = 25;          // sender idle-burst chance per word
   int  sink_pct   = 20;          // receiver stall-burst chance per cycle
   bit  quiet      = 1'b0;        // final stretch: nobody idles
   int  walk_cm    = 100;         // slowly moving target for realistic echoes

   initial begin
      for (int i = 0; i < WINDOW_SIZE; i++) ring_q[i] = '0;
   end

   // Next filtered distance for one accepted pulse width; advances the state.
   function automatic range_word_t next_distance(input logic [PW_W-1:0] pw);
      logic [31:0] raw, val, diff, st, filt, prev;
      logic [63:0] mix;
      q_type       ordered [WINDOW_SIZE];
      q_type       key;
      int          j;
      range_word_t res;
      prev = 32'(prev_out);
      raw  = (32'(pw) * 32'(CM_PER_US_Q)) >> CONV_SHIFT;
      // range gate works on the full Q8 conversion, both bounds exclusive
      if (raw <= (32'(min_cm) << Q_FRAC) || raw >= (32'(max_cm) << Q_FRAC)) begin
         res.distance_cm = prev_out[Q_W-1:Q_FRAC];
         res.rejected    = 1'b1;
         return res;
      end
      val = raw;
      // step limiter, skipped while the output is still zero
      if (prev != 0) begin
         diff = (val > prev) ? val - prev : prev - val;
         if (diff > (32'(jump_cm) << Q_FRAC)) begin
            st = 32'(step_cm) << Q_FRAC;
            if (val > prev)
               val = (prev + st > 32'(Q_MAX)) ? 32'(Q_MAX) : prev + st;
            else
               val = (prev > st) ? prev - st : 32'd0;
         end
      end
      ring_q[slot_q] = val[Q_W-1:0];
      slot_q = (slot_q + 1 >= WINDOW_SIZE) ? 0 : slot_q + 1;
      for (int i = 0; i < WINDOW_SIZE; i++) ordered[i] = ring_q[i];
      for (int i = 1; i < WINDOW_SIZE; i++) begin
         key = ordered[i];
         j = i - 1;
         while (j >= 0 && ordered[j] > key) begin
            ordered[j+1] = ordered[j];
            j--;
         end
         ordered[j+1] = key;
      end
      // 1/4, 1/2, 1/4 on the middle three, then 0.8 old + 0.2 new in Q16
      filt = (32'(ordered[1]) + 2 * 32'(ordered[2]) + 32'(ordered[3])) >> 2;
      mix  = (64'(ALPHA_OLD_Q16) * 64'(prev) + 64'(ALPHA_NEW_Q16) * 64'(filt)) >> BLEND_SHIFT;
      if (mix > 64'(Q_MAX)) mix = 64'(Q_MAX);
      prev_out        = mix[Q_W-1:0];
      res.distance_cm = prev_out[Q_W-1:Q_FRAC];
      res.rejected    = 1'b0;
      return res;
   endfunction

   // Random echo: mostly a wandering target, plus jumps, noise and range edges.
   function automatic logic [PW_W-1:0] pick_pulse();
      int lo, hi, sel, pw, bound;
      lo = int'(min_cm) + 1;
      hi = int'(max_cm) - 1;
      if (lo > hi) begin
         lo = 0;
         hi = 1023;
      end
      sel = $urandom_range(0, 99);
      if (sel < 65)
         walk_cm = walk_cm + int'($urandom_range(0, 16)) - 8;
      else if (sel < 75)
         walk_cm = $urandom_range(lo, hi);      // sudden jump
      if (walk_cm < lo) walk_cm = lo;
      if (walk_cm > hi) walk_cm = hi;
      if (sel < 75) begin
         pw = ((walk_cm * 256 + int'($urandom_range(0, 255))) * 1024) / 4457;
      end else if (sel < 85) begin
         pw = $urandom_range(0, 65535);
      end else if (sel < 95) begin
         // hug the min or max edge within a few microseconds
         bound = $urandom_range(0, 1) ? int'(min_cm) : int'(max_cm);
         pw = (bound * 256 * 1024) / 4457 + int'($urandom_range(0, 6)) - 3;
      end else begin
         case ($urandom_range(0, 2))
            0:       pw = 0;
            1:       pw = 65535;
            default: pw = $urandom_range(60000, 65535);
         endcase
      end
      if (pw < 0) pw = 0;
      if (pw > 65535) pw = 65535;
      return pw[PW_W-1:0];
   endfunction

   // Offer one request word and hold it until the core takes it.
   task automatic offer_word(input logic [PW_W-1:0] pw, input offer_note_t note);
      if (!quiet && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      offered_q.push_back(note);
      req_bus.valid          <= 1'b1;
      req_bus.pulse_width_us <= pw;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   // Register write, only once the pipe has drained.
   task automatic write_reg(input csr_index_type idx, input logic [CM_W-1:0] data);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (distance_q.size() != 0 || offered_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_MIN_RANGE:  min_cm  = data;
         CSR_MAX_RANGE:  max_cm  = data;
         CSR_JUMP_LIMIT: jump_cm = data;
         CSR_STEP:       step_cm = data;
         default:        ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Directed table. Typed answers only where they are obvious: empty
   // filter after reset gives 0 cm on rejection. The rest go through
   // next_distance.
   // ------------------------------------------------------------------
   row_t directed_rows [DIR_ROWS] = '{
      // reset defaults: zero and full-scale echoes both fall outside 2..400 cm
      '{ROW_WORD, CSR_MIN_RANGE,  16'd0,     1'b1, '{10'd0, 1'b1}},
      '{ROW_WORD, CSR_MIN_RANGE,  16'd65535, 1'b1, '{10'd0, 1'b1}},
      // first readings: zero prev, no step limit, zeros still in the window
      '{ROW_WORD, CSR_MIN_RANGE,  16'd5882,  1'b0, '{10'd0, 1'b0}},
      '{ROW_WORD, CSR_MIN_RANGE,  16'd5882,  1'b0, '{10'd0, 1'b0}},
      '{ROW_WORD, CSR_MIN_RANGE,  16'd5882,  1'b0, '{10'd0, 1'b0}},
      '{ROW_WORD, CSR_MIN_RANGE,  16'd5882,  1'b0, '{10'd0, 1'b0}},
      // just above / just below the max bound, the latter a big upward jump
      '{ROW_WORD, CSR_MIN_RANGE,  16'd23527, 1'b0, '{10'd0, 1'b0}},
      '{ROW_WORD, CSR_MIN_RANGE,  16'd23526, 1'b0, '{10'd0, 1'b0}},
      // just above / just below the min bound, downward jump
      '{ROW_WORD, CSR_MIN_RANGE,  16'd118,   1'b0, '{10'd0, 1'b0}},
      '{ROW_WORD, CSR_MIN_RANGE,  16'd117,   1'b0, '{10'd0, 1'b0}},
      // zero jump limit, full step: saturation at zero, then at full scale
      '{ROW_CSR,  CSR_JUMP_LIMIT, 16'd0,     1'b0, '{10'd0, 1'b0}},
      '{ROW_CSR,  CSR_STEP,       16'd1023,  1'b0, '{10'd0, 1'b0}},
      '{ROW_CSR,  CSR_MAX_RANGE,  16'd1023,  1'b0, '{10'd0, 1'b0}},
      '{ROW_WORD, CSR_MIN_RANGE,  16'd1000,  1'b0, '{10'd0, 1'b0}},
      '{ROW_WORD, CSR_MIN_RANGE,  16'd60000, 1'b0, '{10'd0, 1'b0}},
      '{ROW_WORD, CSR_MIN_RANGE,  16'd60000, 1'b0, '{10'd0, 1'b0}},
      // inverted limits: everything rejected, distance held
      '{ROW_CSR,  CSR_MIN_RANGE,  16'd1023,  1'b0, '{10'd0, 1'b0}},
      '{ROW_CSR,  CSR_MAX_RANGE,  16'd0,     1'b0, '{10'd0, 1'b0}},
      '{ROW_WORD, CSR_MIN_RANGE,  16'd5882,  1'b0, '{10'd0, 1'b0}},
      '{ROW_WORD, CSR_MIN_RANGE,  16'd65535, 1'b0, '{10'd0, 1'b0}},
      // widest window, no jump detection, zero step
      '{ROW_CSR,  CSR_MIN_RANGE,  16'd0,     1'b0, '{10'd0, 1'b0}},
      '{ROW_CSR,  CSR_MAX_RANGE,  16'd1023,  1'b0, '{10'd0, 1'b0}},
      '{ROW_CSR,  CSR_JUMP_LIMIT, 16'd1023,  1'b0, '{10'd0, 1'b0}},
      '{ROW_CSR,  CSR_STEP,       16'd0,     1'b0, '{10'd0, 1'b0}},
      '{ROW_WORD, CSR_MIN_RANGE,  16'd1,     1'b0, '{10'd0, 1'b0}},
      '{ROW_WORD, CSR_MIN_RANGE,  16'd60100, 1'b0, '{10'd0, 1'b0}},
      // back to reset values
      '{ROW_CSR,  CSR_MIN_RANGE,  16'd2,     1'b0, '{10'd0, 1'b0}},
      '{ROW_CSR,  CSR_MAX_RANGE,  16'd400,   1'b0, '{10'd0, 1'b0}},
      '{ROW_CSR,  CSR_JUMP_LIMIT, 16'd50,    1'b0, '{10'd0, 1'b0}},
      '{ROW_CSR,  CSR_STEP,       16'd15,    1'b0, '{10'd0, 1'b0}},
      '{ROW_WORD, CSR_MIN_RANGE,  16'd5882,  1'b0, '{10'd0, 1'b0}}
   };

   // ------------------------------------------------------------------
   // Sender: reset, directed table, random phases, drain, verdict
   // ------------------------------------------------------------------
   initial begin
      int n;
      logic [CM_W-1:0] new_min, new_max, new_jump, new_step;
      offer_note_t note;
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.pulse_width_us <= '0;
      csr_we                 <= 1'b0;
      csr_index              <= CSR_MIN_RANGE;
      csr_wdata              <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            write_reg(directed_rows[r].idx, directed_rows[r].value[CM_W-1:0]);
         end else begin
            note.typed = directed_rows[r].typed;
            note.word  = directed_rows[r].word;
            offer_word(directed_rows[r].value, note);
         end
      end

      note = '0;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin   // reset values
               new_min = MIN_RANGE_RST;  new_max = MAX_RANGE_RST;
               new_jump = JUMP_LIMIT_RST; new_step = STEP_RST;
               n = 190; gap_pct = 25; sink_pct = 20;
            end
            1: begin   // typical tuning; long receiver hold falls here
               new_min = $urandom_range(0, 20);  new_max = $urandom_range(300, 1023);
               new_jump = $urandom_range(0, 100); new_step = $urandom_range(1, 60);
               n = 200; gap_pct = 10; sink_pct = 30;
            end
            2: begin   // widest window, every change a jump, huge step
               new_min = '0; new_max = '1; new_jump = '0; new_step = '1;
               n = 170; gap_pct = 0; sink_pct = 40;
            end
            3: begin   // inverted or equal limits
               new_min = $urandom_range(500, 1023);
               new_max = $urandom_range(0, int'(new_min));
               new_jump = $urandom_range(0, 1023); new_step = $urandom_range(0, 1023);
               n = 60; gap_pct = 30; sink_pct = 10;
            end
            4: begin   // anything goes
               new_min = $urandom_range(0, 300);
               new_max = $urandom_range(int'(new_min) + 1, 1023);
               new_jump = $urandom_range(0, 1023); new_step = $urandom_range(0, 1023);
               n = 190; gap_pct = 20; sink_pct = 0;
            end
            5: begin   // tight limiter, tiny steps
               new_min = $urandom_range(0, 5); new_max = $urandom_range(800, 1023);
               new_jump = $urandom_range(0, 5); new_step = $urandom_range(0, 5);
               n = 160; gap_pct = 40; sink_pct = 25;
            end
            default: begin   // closing stretch, both sides flat out
               new_min = $urandom_range(0, 50);    new_max = $urandom_range(200, 1023);
               new_jump = $urandom_range(10, 200); new_step = $urandom_range(1, 100);
               n = 180; gap_pct = 0; sink_pct = 0;
            end
         endcase
         write_reg(CSR_MIN_RANGE, new_min);
         write_reg(CSR_MAX_RANGE, new_max);
         write_reg(CSR_JUMP_LIMIT, new_jump);
         write_reg(CSR_STEP, new_step);
         if (p == PHASES - 1) quiet = 1'b1;
         walk_cm = $urandom_range(int'(new_min), int'(new_max));
         for (int k = 0; k < n; k++) offer_word(pick_pulse(), note);
      end

      // drain: the last word was taken on this edge, its expectation lands now
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (distance_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver: random stall bursts, one long hold-off
   // ------------------------------------------------------------------
   int  stall_left = 0;
   int  hold_left  = 0;
   int  sink_taken = 0;
   bit  hold_done  = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) sink_taken++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && sink_taken >= HOLD_AT_WORD) begin
            // sender keeps offering meanwhile, so the core backs up to req ready low
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_bus.ready <= 1'b0;
         end else if (quiet) begin
            rsp_bus.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (sink_pct > 0 && $urandom_range(0, 99) < sink_pct) begin
            stall_left = $urandom_range(1, 4) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check responses first (they are older), then predict
   // the request taken on the same edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      range_word_t exp_word;
      offer_note_t taken;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            word_count++;
            if (distance_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response word %0d: distance %0d rejected %0b",
                           word_count, rsp_bus.distance_cm, rsp_bus.rejected);
            end else begin
               exp_word = distance_q.pop_front();
               if (rsp_bus.distance_cm !== exp_word.distance_cm ||
                   rsp_bus.rejected !== exp_word.rejected) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch %0d: distance exp %0d got %0d, rejected exp %0b got %0b",
                              word_count, exp_word.distance_cm, rsp_bus.distance_cm,
                              exp_word.rejected, rsp_bus.rejected);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            taken = (offered_q.size() != 0) ? offered_q.pop_front() : '0;
            exp_word = next_distance(req_bus.pulse_width_us);
            distance_q.push_back(taken.typed ? taken.word : exp_word);
         end
      end
   end

   // Watchdog: too long with no word moving on either channel
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                  quiet_cycles, distance_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule

`default_nettype wire
